// File: sv/pcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_pkg
// Shared types, CSR table and codes for the privileged CSR emulator.
// ----------------------------------------------------------------------------
package pcsr_pkg;

  localparam int NUM_CSRS  = 11;
  localparam int CSR_IDX_W = $clog2(NUM_CSRS);
  localparam int XLEN      = 64;

  localparam logic [1:0] MODE_U = 2'd0;
  localparam logic [1:0] MODE_S = 2'd1;
  localparam logic [1:0] MODE_M = 2'd2;

  localparam logic [2:0] F3_CSRW = 3'd1;
  localparam logic [2:0] F3_CSRR = 3'd2;

  localparam logic [11:0] CODE_MRET  = 12'h302;
  localparam logic [11:0] CODE_SRET  = 12'h102;
  localparam logic [11:0] CODE_ECALL = 12'h000;

  localparam logic [CSR_IDX_W-1:0] IDX_MHARTID = CSR_IDX_W'(0);
  localparam logic [CSR_IDX_W-1:0] IDX_MEPC    = CSR_IDX_W'(1);
  localparam logic [CSR_IDX_W-1:0] IDX_MSTATUS = CSR_IDX_W'(2);
  localparam logic [CSR_IDX_W-1:0] IDX_SATP    = CSR_IDX_W'(3);
  localparam logic [CSR_IDX_W-1:0] IDX_MEDELEG = CSR_IDX_W'(4);
  localparam logic [CSR_IDX_W-1:0] IDX_MIDELEG = CSR_IDX_W'(5);
  localparam logic [CSR_IDX_W-1:0] IDX_SIE     = CSR_IDX_W'(6);
  localparam logic [CSR_IDX_W-1:0] IDX_STVEC   = CSR_IDX_W'(7);
  localparam logic [CSR_IDX_W-1:0] IDX_SSTATUS = CSR_IDX_W'(8);
  localparam logic [CSR_IDX_W-1:0] IDX_SEPC    = CSR_IDX_W'(9);
  localparam logic [CSR_IDX_W-1:0] IDX_MTVEC   = CSR_IDX_W'(10);

  localparam logic [XLEN-1:0] MPP_MASK    = XLEN'(16'h1800);
  localparam logic [XLEN-1:0] MPP_SUPER   = XLEN'(16'h0800);
  localparam logic [XLEN-1:0] SIE_ENABLES = XLEN'(16'h0222);
  localparam logic [XLEN-1:0] SPP_BIT     = XLEN'(16'h0100);
  localparam logic [XLEN-1:0] SPIE_BIT    = XLEN'(16'h0020);
  localparam logic [XLEN-1:0] DELEG_ALL   = XLEN'(16'hffff);
  localparam logic [XLEN-1:0] PC_STEP     = XLEN'(4);

  typedef logic [XLEN-1:0] csr_file_t [NUM_CSRS];

  typedef struct packed {
    logic            dest_write;
    logic [4:0]      dest_index;
    logic [XLEN-1:0] dest_value;
    logic            pc_write;
    logic [XLEN-1:0] next_pc;
    logic            fault;
    logic [1:0]      mode_now;
  } result_t;

  function automatic logic [11:0] csr_code(input logic [CSR_IDX_W-1:0] idx);
    logic [11:0] code;
    unique case (idx)
      IDX_MHARTID: code = 12'hF14;
      IDX_MEPC:    code = 12'h341;
      IDX_MSTATUS: code = 12'h300;
      IDX_SATP:    code = 12'h180;
      IDX_MEDELEG: code = 12'h302;
      IDX_MIDELEG: code = 12'h303;
      IDX_SIE:     code = 12'h104;
      IDX_STVEC:   code = 12'h105;
      IDX_SSTATUS: code = 12'h100;
      IDX_SEPC:    code = 12'h141;
      IDX_MTVEC:   code = 12'h305;
      default:     code = 12'h000;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] csr_level(input logic [CSR_IDX_W-1:0] idx);
    logic [1:0] lvl;
    unique case (idx)
      IDX_SATP, IDX_SIE, IDX_STVEC, IDX_SSTATUS, IDX_SEPC: lvl = MODE_S;
      default: lvl = MODE_M;
    endcase
    return lvl;
  endfunction

endpackage

// File: sv/privileged_csr_emulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// privileged_csr_emulator
// Trap-and-emulate unit for privileged CSR instructions, mret, sret, ecall.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, one per clock sustained while
// result_ready is held high. The instruction is captured in an input register,
// executed against the virtual CSR file and mode from that register, and the
// result lands in an output register while the CSR file and mode update at
// the same edge. Each instruction sees the state left by the one before it.
module privileged_csr_emulator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [31:0]               instruction,
  input  logic [pcsr_pkg::XLEN-1:0] source_value,
  input  logic [pcsr_pkg::XLEN-1:0] trap_pc,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      dest_write,
  output logic [4:0]                dest_index,
  output logic [pcsr_pkg::XLEN-1:0] dest_value,
  output logic                      pc_write,
  output logic [pcsr_pkg::XLEN-1:0] next_pc,
  output logic                      fault,
  output logic [1:0]                mode_now
);

  pcsr_pkg::csr_file_t csr_values;
  pcsr_pkg::csr_file_t csr_values_next;
  logic [1:0]          priv_mode;
  logic [1:0]          priv_mode_next;

  logic                      stage_valid;
  logic [31:0]               stage_instruction;
  logic [pcsr_pkg::XLEN-1:0] stage_source_value;
  logic [pcsr_pkg::XLEN-1:0] stage_trap_pc;

  pcsr_pkg::result_t result;
  logic              advance;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  pcsr_exec u_exec (
    .instruction     (stage_instruction),
    .source_value    (stage_source_value),
    .trap_pc         (stage_trap_pc),
    .csr_values      (csr_values),
    .priv_mode       (priv_mode),
    .csr_values_next (csr_values_next),
    .priv_mode_next  (priv_mode_next),
    .result          (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      stage_instruction  <= instruction;
      stage_source_value <= source_value;
      stage_trap_pc      <= trap_pc;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcsr_pkg::NUM_CSRS; i++) begin
        csr_values[i] <= '0;
      end
      priv_mode <= pcsr_pkg::MODE_M;
    end else if (advance) begin
      csr_values <= csr_values_next;
      priv_mode  <= priv_mode_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      dest_write <= result.dest_write;
      dest_index <= result.dest_index;
      dest_value <= result.dest_value;
      pc_write   <= result.pc_write;
      next_pc    <= result.next_pc;
      fault      <= result.fault;
      mode_now   <= result.mode_now;
    end
  end

endmodule

// File: sv/pcsr_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_exec
// Decode and execute one trapped instruction against the CSR file and mode;
// gives the result and the next CSR file and mode.
// ----------------------------------------------------------------------------
module pcsr_exec (
  input  logic [31:0]              instruction,
  input  logic [pcsr_pkg::XLEN-1:0] source_value,
  input  logic [pcsr_pkg::XLEN-1:0] trap_pc,
  input  pcsr_pkg::csr_file_t      csr_values,
  input  logic [1:0]               priv_mode,
  output pcsr_pkg::csr_file_t      csr_values_next,
  output logic [1:0]               priv_mode_next,
  output pcsr_pkg::result_t        result
);

  logic [4:0]  rd;
  logic [2:0]  funct3;
  logic [11:0] csr;
  logic        hit;
  logic [pcsr_pkg::CSR_IDX_W-1:0] k;

  assign rd     = instruction[11:7];
  assign funct3 = instruction[14:12];
  assign csr    = instruction[31:20];

  // table lookup
  always_comb begin
    hit = 1'b0;
    k   = '0;
    for (int i = 0; i < pcsr_pkg::NUM_CSRS; i++) begin
      if (!hit && pcsr_pkg::csr_code(pcsr_pkg::CSR_IDX_W'(i)) == csr) begin
        hit = 1'b1;
        k   = pcsr_pkg::CSR_IDX_W'(i);
      end
    end
  end

  always_comb begin
    csr_values_next = csr_values;
    priv_mode_next  = priv_mode;
    result          = '0;
    if (funct3 == pcsr_pkg::F3_CSRW || funct3 == pcsr_pkg::F3_CSRR) begin
      if (!hit || priv_mode < pcsr_pkg::csr_level(k)) begin
        result.fault = 1'b1;
      end else if (funct3 == pcsr_pkg::F3_CSRW) begin
        csr_values_next[k] = source_value;
      end else if (rd >= 5'd10 && rd <= 5'd15) begin
        result.dest_write = 1'b1;
        result.dest_index = rd;
        result.dest_value = csr_values[k];
      end
    end else if (csr == pcsr_pkg::CODE_MRET) begin
      if (priv_mode == pcsr_pkg::MODE_M) begin
        csr_values_next[pcsr_pkg::IDX_MSTATUS] =
          (csr_values[pcsr_pkg::IDX_MSTATUS] & ~pcsr_pkg::MPP_MASK) | pcsr_pkg::MPP_SUPER;
        csr_values_next[pcsr_pkg::IDX_SATP]    = '0;
        csr_values_next[pcsr_pkg::IDX_MEDELEG] = pcsr_pkg::DELEG_ALL;
        csr_values_next[pcsr_pkg::IDX_MIDELEG] = pcsr_pkg::DELEG_ALL;
        csr_values_next[pcsr_pkg::IDX_SIE]     =
          csr_values[pcsr_pkg::IDX_SIE] | pcsr_pkg::SIE_ENABLES;
        result.pc_write = 1'b1;
        result.next_pc  = csr_values[pcsr_pkg::IDX_MEPC] - pcsr_pkg::PC_STEP;
        priv_mode_next  = pcsr_pkg::MODE_S;
      end else begin
        result.fault = 1'b1;
      end
    end else if (csr == pcsr_pkg::CODE_SRET) begin
      if (priv_mode == pcsr_pkg::MODE_S) begin
        csr_values_next[pcsr_pkg::IDX_SSTATUS] =
          (csr_values[pcsr_pkg::IDX_SSTATUS] & ~pcsr_pkg::SPP_BIT) | pcsr_pkg::SPIE_BIT;
        result.pc_write = 1'b1;
        result.next_pc  = csr_values[pcsr_pkg::IDX_SEPC] - pcsr_pkg::PC_STEP;
        priv_mode_next  = pcsr_pkg::MODE_U;
      end else begin
        result.fault = 1'b1;
      end
    end else if (csr == pcsr_pkg::CODE_ECALL) begin
      if (priv_mode == pcsr_pkg::MODE_U) begin
        csr_values_next[pcsr_pkg::IDX_SEPC] = trap_pc;
        result.pc_write = 1'b1;
        result.next_pc  = csr_values[pcsr_pkg::IDX_STVEC] - pcsr_pkg::PC_STEP;
        priv_mode_next  = pcsr_pkg::MODE_S;
      end else if (priv_mode == pcsr_pkg::MODE_S) begin
        csr_values_next[pcsr_pkg::IDX_MEPC] = trap_pc;
        result.pc_write = 1'b1;
        result.next_pc  = csr_values[pcsr_pkg::IDX_MTVEC] - pcsr_pkg::PC_STEP;
        priv_mode_next  = pcsr_pkg::MODE_M;
      end else begin
        result.fault = 1'b1;
      end
    end
    result.mode_now = priv_mode_next;
  end

endmodule

// File: sv/pcsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_checker
// Port-level checks on result transactions of the privileged CSR emulator.
// ----------------------------------------------------------------------------
module pcsr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      result_valid,
  input logic                      dest_write,
  input logic [4:0]                dest_index,
  input logic [pcsr_pkg::XLEN-1:0] dest_value,
  input logic                      pc_write,
  input logic                      fault,
  input logic [1:0]                mode_now
);

  // a faulting transaction has no side effect
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && fault |-> !dest_write && !pc_write)
    else $error("fault with register or pc write");

  // register writes only to x10..x15
  a_dest_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && dest_write |-> dest_index >= 5'd10 && dest_index <= 5'd15)
    else $error("destination outside x10..x15");

  // no destination write means zero index and value
  a_dest_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !dest_write |-> dest_index == 5'd0 && dest_value == '0)
    else $error("stale destination fields");

  // never both a register write and a pc write, and never mode 3
  a_one_effect: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(dest_write && pc_write) && mode_now != 2'd3)
    else $error("bad result combination");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind privileged_csr_emulator pcsr_checker u_pcsr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .dest_write   (dest_write),
  .dest_index   (dest_index),
  .dest_value   (dest_value),
  .pc_write     (pc_write),
  .fault        (fault),
  .mode_now     (mode_now)
);
